@@ rtl/core/vct_pkg.sv @@
// shared types and defaults for the value count tree core
// no dependencies
package vct_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int ANSWER_BITS    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_COUNT  = 2'd1,
        OP_KTH    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic fail;
    } ctrl_t;

endpackage

@@ rtl/core/vct_root_cell.sv @@
// root cell of the count chain: holds the total, decodes the operation
// depends on vct_pkg
module vct_root_cell #(
    parameter int VALUE_BITS = vct_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = vct_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            func,
    input  logic [15:0]           value,
    input  logic [15:0]           range_low,
    input  logic [15:0]           range_high,
    input  logic [31:0]           rank,
    output vct_pkg::ctrl_t        out_ctl,
    output logic [VALUE_BITS-1:0] out_key,
    output logic [VALUE_BITS-1:0] out_hi,
    output logic [COUNT_BITS-1:0] out_acc_lo,
    output logic [COUNT_BITS-1:0] out_acc_hi,
    output logic [COUNT_BITS-1:0] out_total
);

    localparam int EXT = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    logic [COUNT_BITS-1:0] root_reg, root_next;
    vct_pkg::ctrl_t        ctl_reg, ctl_next;
    logic [VALUE_BITS-1:0] key_reg, key_next, hi_reg;
    logic [COUNT_BITS-1:0] acc_reg, acc_next, total_reg;
    logic [VALUE_BITS-1:0] lo_m, hi_m;
    logic [EXT-1:0]        rank_x, total_x;

    always_comb
    begin
        lo_m      = VALUE_BITS'(range_low);
        hi_m      = VALUE_BITS'(range_high);
        rank_x    = EXT'(rank);
        total_x   = EXT'(root_reg);
        root_next = root_reg;
        ctl_next  = '{valid: start, op: vct_pkg::OP_NONE, fail: 1'b0};
        key_next  = '0;
        acc_next  = '0;
        unique case (func)
            vct_pkg::OP_INSERT:
            begin
                key_next = VALUE_BITS'(value);
                if (root_reg == '1)
                begin
                    ctl_next.fail = 1'b1;
                end
                else
                begin
                    ctl_next.op = vct_pkg::OP_INSERT;
                    if (start)
                    begin
                        root_next = root_reg + 1'b1;
                    end
                end
            end
            vct_pkg::OP_COUNT:
            begin
                key_next = lo_m;
                if (lo_m <= hi_m)
                begin
                    ctl_next.op = vct_pkg::OP_COUNT;
                end
            end
            vct_pkg::OP_KTH:
            begin
                acc_next = COUNT_BITS'(rank_x);
                if (rank == '0 || rank_x > total_x)
                begin
                    ctl_next.fail = 1'b1;
                end
                else
                begin
                    ctl_next.op = vct_pkg::OP_KTH;
                end
            end
            default:
            begin
                ctl_next.op = vct_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            ctl_reg  <= '{valid: 1'b0, op: vct_pkg::OP_NONE, fail: 1'b0};
        end
        else
        begin
            root_reg <= root_next;
            ctl_reg  <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg   <= key_next;
            hi_reg    <= hi_m;
            acc_reg   <= acc_next;
            total_reg <= root_reg;
        end
    end

    assign out_ctl    = ctl_reg;
    assign out_key    = key_reg;
    assign out_hi     = hi_reg;
    assign out_acc_lo = acc_reg;
    assign out_acc_hi = '0;
    assign out_total  = total_reg;

endmodule

@@ rtl/core/vct_level_cell.sv @@
// one tree level of the count chain: node memory plus descent step
// depends on vct_pkg
module vct_level_cell #(
    parameter int VALUE_BITS = vct_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = vct_pkg::COUNT_BITS_DEF,
    parameter int LEVEL      = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clr_active,
    input  logic [VALUE_BITS-1:0] clr_addr,
    input  vct_pkg::ctrl_t        in_ctl,
    input  logic [VALUE_BITS-1:0] in_key,
    input  logic [VALUE_BITS-1:0] in_hi,
    input  logic [COUNT_BITS-1:0] in_acc_lo,
    input  logic [COUNT_BITS-1:0] in_acc_hi,
    input  logic [COUNT_BITS-1:0] in_total,
    output vct_pkg::ctrl_t        out_ctl,
    output logic [VALUE_BITS-1:0] out_key,
    output logic [VALUE_BITS-1:0] out_hi,
    output logic [COUNT_BITS-1:0] out_acc_lo,
    output logic [COUNT_BITS-1:0] out_acc_hi,
    output logic [COUNT_BITS-1:0] out_total
);

    localparam int AW  = LEVEL;
    localparam int SH  = VALUE_BITS - LEVEL;

    logic [COUNT_BITS-1:0] mem [2**AW];

    vct_pkg::ctrl_t        ctl_reg;
    logic [VALUE_BITS-1:0] key_reg, hi_reg;
    logic [COUNT_BITS-1:0] acc_lo_reg, acc_hi_reg, total_reg;
    logic [COUNT_BITS-1:0] rda_reg, rdb_reg;
    logic [AW-1:0]         waddr_reg;
    logic [AW-1:0]         a_addr, b_addr, w_addr;
    logic [COUNT_BITS-1:0] w_data;
    logic                  we;

    always_comb
    begin
        a_addr = AW'(in_key >> SH);
        // queries read the left child of the path so far
        if (in_ctl.op != vct_pkg::OP_INSERT)
        begin
            a_addr[0] = 1'b0;
        end
        b_addr = AW'(in_hi >> SH) | AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, op: vct_pkg::OP_NONE, fail: 1'b0};
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid)
        begin
            key_reg    <= in_key;
            hi_reg     <= in_hi;
            acc_lo_reg <= in_acc_lo;
            acc_hi_reg <= in_acc_hi;
            total_reg  <= in_total;
            waddr_reg  <= a_addr;
            rda_reg    <= mem[a_addr];
            rdb_reg    <= mem[b_addr];
        end
        if (we)
        begin
            mem[w_addr] <= w_data;
        end
    end

    always_comb
    begin
        we     = clr_active || (ctl_reg.valid && ctl_reg.op == vct_pkg::OP_INSERT);
        w_addr = clr_active ? AW'(clr_addr) : waddr_reg;
        w_data = clr_active ? '0 : rda_reg + 1'b1;

        out_ctl    = ctl_reg;
        out_key    = key_reg;
        out_hi     = hi_reg;
        out_acc_lo = acc_lo_reg;
        out_acc_hi = acc_hi_reg;
        out_total  = total_reg;
        unique case (ctl_reg.op)
            vct_pkg::OP_COUNT:
            begin
                // values below lo on the left, values above hi on the right
                if (key_reg[SH])
                begin
                    out_acc_lo = acc_lo_reg + rda_reg;
                end
                if (!hi_reg[SH])
                begin
                    out_acc_hi = acc_hi_reg + rdb_reg;
                end
            end
            vct_pkg::OP_KTH:
            begin
                if (acc_lo_reg > rda_reg)
                begin
                    out_acc_lo = acc_lo_reg - rda_reg;
                    out_key    = key_reg | (VALUE_BITS'(1) << SH);
                end
            end
            vct_pkg::OP_INSERT, vct_pkg::OP_NONE:
            begin
                out_acc_lo = acc_lo_reg;
            end
        endcase
    end

endmodule

@@ rtl/core/value_count_tree_core.sv @@
// top level of the value count tree: root cell, chain of level cells, output register
// depends on vct_pkg, vct_root_cell, vct_level_cell
//
// Keeps an occurrence count for every value of the domain in a tree, one level per cell,
// each level in its own memory. A transaction is an insert, a range count or a k-th
// smallest lookup; it walks from the root cell down the chain one level per cycle and its
// result is held in the output register. Only one transaction is in the chain at a time,
// and the next can be accepted in the same cycle that the previous result is taken. After
// reset the level memories are cleared in parallel, one address a cycle, through all
// 2^VALUE_BITS counter values; in_ready stays low during that pass.
module value_count_tree_core #(
    parameter int VALUE_BITS = vct_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = vct_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] value,
    input  logic [15:0] range_low,
    input  logic [15:0] range_high,
    input  logic [31:0] rank,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] answer,
    output logic        failed
);

    localparam int AB  = vct_pkg::ANSWER_BITS;
    localparam int EXT = (COUNT_BITS > AB) ? COUNT_BITS : AB;

    vct_pkg::ctrl_t        st_ctl    [VALUE_BITS+1];
    logic [VALUE_BITS-1:0] st_key    [VALUE_BITS+1];
    logic [VALUE_BITS-1:0] st_hi     [VALUE_BITS+1];
    logic [COUNT_BITS-1:0] st_acc_lo [VALUE_BITS+1];
    logic [COUNT_BITS-1:0] st_acc_hi [VALUE_BITS+1];
    logic [COUNT_BITS-1:0] st_total  [VALUE_BITS+1];

    logic                  clearing_reg;
    logic [VALUE_BITS-1:0] clr_cnt_reg;
    logic                  busy_reg, busy_next;
    logic                  out_valid_reg;
    logic [AB-1:0]         answer_reg, answer_next;
    logic                  failed_reg;
    logic                  start;
    logic [COUNT_BITS-1:0] diff;
    logic [EXT-1:0]        diff_x;
    vct_pkg::ctrl_t        fin;

    assign in_ready = !clearing_reg && !busy_reg && (!out_valid_reg || out_ready);
    assign start    = in_valid && in_ready;

    vct_root_cell #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .value      (value),
        .range_low  (range_low),
        .range_high (range_high),
        .rank       (rank),
        .out_ctl    (st_ctl[0]),
        .out_key    (st_key[0]),
        .out_hi     (st_hi[0]),
        .out_acc_lo (st_acc_lo[0]),
        .out_acc_hi (st_acc_hi[0]),
        .out_total  (st_total[0])
    );

    for (genvar g = 1; g <= VALUE_BITS; g++)
    begin : g_level
        vct_level_cell #(
            .VALUE_BITS(VALUE_BITS),
            .COUNT_BITS(COUNT_BITS),
            .LEVEL     (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .clr_active (clearing_reg),
            .clr_addr   (clr_cnt_reg),
            .in_ctl     (st_ctl[g-1]),
            .in_key     (st_key[g-1]),
            .in_hi      (st_hi[g-1]),
            .in_acc_lo  (st_acc_lo[g-1]),
            .in_acc_hi  (st_acc_hi[g-1]),
            .in_total   (st_total[g-1]),
            .out_ctl    (st_ctl[g]),
            .out_key    (st_key[g]),
            .out_hi     (st_hi[g]),
            .out_acc_lo (st_acc_lo[g]),
            .out_acc_hi (st_acc_hi[g]),
            .out_total  (st_total[g])
        );
    end

    always_comb
    begin
        fin    = st_ctl[VALUE_BITS];
        diff   = st_total[VALUE_BITS] - st_acc_lo[VALUE_BITS] - st_acc_hi[VALUE_BITS];
        diff_x = EXT'(diff);
        unique case (fin.op)
            vct_pkg::OP_COUNT:
            begin
                answer_next = (diff_x > EXT'({AB{1'b1}})) ? {AB{1'b1}} : AB'(diff_x);
            end
            vct_pkg::OP_KTH:
            begin
                answer_next = AB'(st_key[VALUE_BITS]);
            end
            vct_pkg::OP_INSERT, vct_pkg::OP_NONE:
            begin
                answer_next = '0;
            end
        endcase
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (fin.valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            busy_reg <= busy_next;
            if (fin.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            answer_reg <= answer_next;
            failed_reg <= fin.fail;
        end
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign failed    = failed_reg;

endmodule

@@ sim/value_count_tree_core_tb.sv @@
// self-checking testbench for value_count_tree_core: random and directed insert,
// range count and k-th transactions checked against a behavioral count model
// depends on vct_pkg and value_count_tree_core
module value_count_tree_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vct_pkg::*;

    typedef struct {
        op_t         op;
        logic [15:0] value;
        logic [15:0] range_low;
        logic [15:0] range_high;
        logic [31:0] rank;
    } request_t;

    typedef struct {
        logic [31:0] answer;
        logic        failed;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [15:0] value;
    logic [15:0] range_low;
    logic [15:0] range_high;
    logic [31:0] rank;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] answer;
    logic        failed;

    value_count_tree_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .value      (value),
        .range_low  (range_low),
        .range_high (range_high),
        .rank       (rank),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .answer     (answer),
        .failed     (failed)
    );

    // occurrence counts per value; total kept separately
    int unsigned value_hist [int unsigned];
    longint unsigned stored_total;

    request_t pending_q[$];
    reply_t   reply_q[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       mismatch_count;
    bit       hold_sender;

    function automatic reply_t predict_reply(request_t req);
        reply_t r;
        longint unsigned sum;
        longint unsigned k;
        r.answer = '0;
        r.failed = 1'b0;
        case (req.op)
            OP_INSERT:
            begin
                if (stored_total >= 64'hFFFF_FFFF)
                    r.failed = 1'b1;
                else
                begin
                    if (value_hist.exists(req.value))
                        value_hist[req.value]++;
                    else
                        value_hist[req.value] = 1;
                    stored_total++;
                end
            end
            OP_COUNT:
            begin
                sum = 0;
                if (req.range_low <= req.range_high)
                    foreach (value_hist[v])
                        if (v >= req.range_low && v <= req.range_high)
                            sum += value_hist[v];
                r.answer = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
            OP_KTH:
            begin
                k = req.rank;
                if (k == 0 || k > stored_total)
                    r.failed = 1'b1;
                else
                    foreach (value_hist[v])
                    begin
                        if (k <= value_hist[v])
                        begin
                            r.answer = v;
                            break;
                        end
                        k -= value_hist[v];
                    end
            end
            default: ;
        endcase
        return r;
    endfunction

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= OP_NONE;
            value      <= '0;
            range_low  <= '0;
            range_high <= '0;
            rank       <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                reply_q.push_back(predict_reply(pending_q.pop_front()));
            if (pending_q.size() > 0 && !hold_sender
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid   <= 1'b1;
                func       <= pending_q[0].op;
                value      <= pending_q[0].value;
                range_low  <= pending_q[0].range_low;
                range_high <= pending_q[0].range_high;
                rank       <= pending_q[0].rank;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        reply_t exp_r;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transaction: answer %0d failed %0b",
                                 answer, failed);
                end
                else
                begin
                    exp_r = reply_q.pop_front();
                    if (exp_r.answer !== answer || exp_r.failed !== failed)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected answer %0d failed %0b, got %0d %0b",
                                     exp_r.answer, exp_r.failed, answer, failed);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic request_t make_req(op_t op, int unsigned v, int unsigned lo,
                                          int unsigned hi, int unsigned k);
        request_t r;
        r.op = op;
        r.value = v[15:0];
        r.range_low = lo[15:0];
        r.range_high = hi[15:0];
        r.rank = k;
        return r;
    endfunction

    function automatic request_t random_req();
        int unsigned sel;
        int unsigned base;
        sel = $urandom_range(99);
        base = $urandom_range(1) ? $urandom_range(40) : $urandom_range(65535);
        if (sel < 45)
            return make_req(OP_INSERT,
                            ($urandom_range(3) == 0) ? $urandom : base + $urandom_range(8),
                            $urandom, $urandom, $urandom);
        else if (sel < 70)
            return make_req(OP_COUNT, $urandom, base,
                            ($urandom_range(4) == 0) ? $urandom : base + $urandom_range(2000),
                            $urandom);
        else if (sel < 95)
            return make_req(OP_KTH, $urandom, $urandom, $urandom,
                            ($urandom_range(5) == 0) ? $urandom
                                                     : $urandom_range(stored_total + 3));
        else
            return make_req(OP_NONE, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_valid || reply_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 81;
        mismatch_count = 0;
        hold_sender = 1'b0;
        stored_total = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty tree, extremes, bad ranks, empty range, unused func
        pending_q.push_back(make_req(OP_KTH, 0, 0, 0, 1));
        pending_q.push_back(make_req(OP_COUNT, 0, 0, 65535, 0));
        pending_q.push_back(make_req(OP_INSERT, 0, 65535, 0, 32'hFFFF_FFFF));
        pending_q.push_back(make_req(OP_INSERT, 65535, 0, 65535, 0));
        pending_q.push_back(make_req(OP_INSERT, 65535, 0, 0, 0));
        pending_q.push_back(make_req(OP_INSERT, 16'h5555, 0, 0, 0));
        pending_q.push_back(make_req(OP_INSERT, 16'hAAAA, 0, 0, 0));
        pending_q.push_back(make_req(OP_COUNT, 0, 0, 65535, 0));
        pending_q.push_back(make_req(OP_COUNT, 0, 65535, 65535, 0));
        pending_q.push_back(make_req(OP_COUNT, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_COUNT, 0, 16'hAAAA, 16'h5555, 0));
        pending_q.push_back(make_req(OP_COUNT, 0, 16'h5555, 16'hAAAA, 0));
        pending_q.push_back(make_req(OP_KTH, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_KTH, 0, 0, 0, 1));
        pending_q.push_back(make_req(OP_KTH, 0, 0, 0, 3));
        pending_q.push_back(make_req(OP_KTH, 0, 0, 0, 5));
        pending_q.push_back(make_req(OP_KTH, 0, 0, 0, 6));
        pending_q.push_back(make_req(OP_KTH, 0, 0, 0, 32'hFFFF_FFFF));
        pending_q.push_back(make_req(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        wait_drained();

        // sender holds off until everything is back
        hold_sender = 1'b1;
        repeat (3) pending_q.push_back(random_req());
        repeat (60) @(posedge clk);
        wait (reply_q.size() == 0);
        @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        // random phases; stored_total used by random_req is current once drained
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 28 : 0;
            for (int i = 0; i < 310; i++)
            begin
                pending_q.push_back(random_req());
                if (i % 8 == 7)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && reply_q.size() == 0)
            $display("value_count_tree_core regression: pass");
        else
            $display("value_count_tree_core regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("value_count_tree_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/vct_pkg.sv
rtl/core/vct_root_cell.sv
rtl/core/vct_level_cell.sv
rtl/core/value_count_tree_core.sv
sim/value_count_tree_core_tb.sv
